### rtl/hkal_pkg.sv
package hkal_pkg;

  localparam int CFG_BITS = 11;
  localparam int KEY_BITS = 10;
  localparam int VAL_BITS = 63;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [KEY_BITS-1:0] req_key;
    logic [VAL_BITS-1:0] req_value;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [KEY_BITS-1:0] out_key;
    logic [VAL_BITS-1:0] out_value;
  } res_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] initial_entries;
    logic [CFG_BITS-1:0] grow_step;
    logic [CFG_BITS-1:0] maximum_entries;
  } cfg_t;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_INSERT_AT = 3'd1;
  localparam logic [2:0] OP_GET       = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_RESET     = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BEYOND    = 3'd4;
  localparam logic [2:0] ST_NOT_POP   = 3'd5;

  localparam logic [1:0] REG_INITIAL = 2'd0;
  localparam logic [1:0] REG_GROW    = 2'd1;
  localparam logic [1:0] REG_MAXIMUM = 2'd2;

  localparam logic [CFG_BITS-1:0] INITIAL_RST = 11'd0;
  localparam logic [CFG_BITS-1:0] GROW_RST    = 11'd64;
  localparam logic [CFG_BITS-1:0] MAXIMUM_RST = 11'd1024;

endpackage

### rtl/hkal_cfg.sv
module hkal_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output hkal_pkg::cfg_t      cfg
);
  import hkal_pkg::*;

  cfg_t cfg_r;
  logic wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_entries <= INITIAL_RST;
      cfg_r.grow_step       <= GROW_RST;
      cfg_r.maximum_entries <= MAXIMUM_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_INITIAL: cfg_r.initial_entries <= pwdata[CFG_BITS-1:0];
        REG_GROW:    cfg_r.grow_step       <= pwdata[CFG_BITS-1:0];
        REG_MAXIMUM: cfg_r.maximum_entries <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INITIAL: prdata = 32'(cfg_r.initial_entries);
      REG_GROW:    prdata = 32'(cfg_r.grow_step);
      REG_MAXIMUM: prdata = 32'(cfg_r.maximum_entries);
      default:     prdata = 32'd0;
    endcase
  end

endmodule

### rtl/hkal_ctrl.sv
module hkal_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 63
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hkal_pkg::req_t in_req,
  input  hkal_pkg::cfg_t cfg,
  output logic           out_valid,
  output hkal_pkg::res_t out_res
);
  import hkal_pkg::*;

  localparam int KW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;

  typedef struct packed {
    logic          valid;
    logic [KW-1:0] nxt;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_GROW_LINK, S_GROW_FILL, S_INS_RD, S_INS_UNL,
    S_INSAT_CHK, S_WALK, S_CLAIM, S_GET_CHK, S_REM_CHK
  } state_t;

  typedef enum logic [1:0] {RET_INS, RET_INSAT, RET_DONE} ret_t;

  meta_t                 meta_mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem  [TABLE_DEPTH];
  meta_t                 meta_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  logic                  meta_we, val_we;
  logic [KW-1:0]         meta_wa, meta_ra;
  meta_t                 meta_wd;

  state_t                state_r, state_nxt;
  ret_t                  ret_r, ret_nxt;
  logic [2:0]            type_r, type_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [KW-1:0]         head_r, head_nxt, tail_r, tail_nxt;
  logic [KW-1:0]         prev_r, prev_nxt, knext_r, knext_nxt;
  logic                  empty_r, empty_nxt;
  logic [CW-1:0]         pop_r, pop_nxt, gk_r, gk_nxt, gend_r, gend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  res_r, res_nxt;

  logic [KW-1:0]         key_i;
  logic [LW-1:0]         key_l, lim, pop_base, gstep, room, gn, init_c;
  logic [CW-1:0]         gk_inc;
  logic                  gfail, fin;
  logic [2:0]            fin_st;
  logic [KEY_BITS-1:0]   fin_key;
  logic [VAL_BITS-1:0]   fin_val;

  assign key_i  = KW'(key_r);
  assign key_l  = LW'(key_r);
  assign lim    = (LW'(cfg.maximum_entries) > LW'(TABLE_DEPTH)) ?
                  LW'(TABLE_DEPTH) : LW'(cfg.maximum_entries);
  assign init_c = (LW'(cfg.initial_entries) > lim) ? lim : LW'(cfg.initial_entries);
  assign pop_base = (type_r == OP_RESET) ? '0 : LW'(pop_r);
  assign gstep  = (type_r == OP_RESET) ? init_c :
                  ((cfg.grow_step == '0) ? LW'(1) : LW'(cfg.grow_step));
  assign gfail  = pop_base >= lim;
  assign room   = lim - pop_base;
  assign gn     = (gstep > room) ? room : gstep;
  assign gk_inc = gk_r + CW'(1);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_r <= meta_mem[meta_ra];
    if (val_we) val_mem[meta_wa] <= value_r;
    val_rd_r <= val_mem[key_i];
  end

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;
    type_nxt = type_r;    key_nxt = key_r;     value_nxt = value_r;
    head_nxt = head_r;    tail_nxt = tail_r;   empty_nxt = empty_r;
    prev_nxt = prev_r;    knext_nxt = knext_r;
    pop_nxt = pop_r;      gk_nxt = gk_r;       gend_nxt = gend_r;
    res_nxt = res_r;      out_valid_nxt = 1'b0;
    meta_we = 1'b0;       meta_wa = key_i;     meta_wd = '0;
    meta_ra = key_i;      val_we = 1'b0;
    fin = 1'b0;           fin_st = ST_OK;      fin_key = key_r;  fin_val = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          type_nxt  = in_req.req_type;
          key_nxt   = in_req.req_key;
          value_nxt = VALUE_BITS'(in_req.req_value);
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (type_r)
          OP_INSERT, OP_INSERT_AT, OP_RESET: begin
            if (type_r == OP_INSERT_AT && key_l >= lim) begin
              fin = 1'b1; fin_st = ST_BEYOND;
            end else if (type_r == OP_INSERT && !empty_r) begin
              state_nxt = S_INS_RD;
            end else if (type_r == OP_INSERT_AT && CW'(key_r) < pop_r) begin
              state_nxt = S_INSAT_CHK;
            end else if (type_r == OP_RESET && init_c == '0) begin
              pop_nxt = '0; empty_nxt = 1'b1; head_nxt = '0; tail_nxt = '0;
              fin = 1'b1;
            end else if (gfail) begin
              fin = 1'b1; fin_st = ST_NO_SPACE;
            end else begin
              if (type_r == OP_RESET) begin
                pop_nxt = '0; empty_nxt = 1'b1; head_nxt = '0; tail_nxt = '0;
              end
              gk_nxt    = CW'(pop_base);
              gend_nxt  = CW'(pop_base + gn);
              ret_nxt   = (type_r == OP_INSERT) ? RET_INS :
                          (type_r == OP_INSERT_AT) ? RET_INSAT : RET_DONE;
              state_nxt = (empty_r || type_r == OP_RESET) ? S_GROW_FILL : S_GROW_LINK;
            end
          end
          OP_GET, OP_REMOVE: begin
            if (CW'(key_r) >= pop_r || LW'(key_r) >= LW'(TABLE_DEPTH)) begin
              fin = 1'b1; fin_st = ST_NOT_POP;
            end else begin
              state_nxt = (type_r == OP_GET) ? S_GET_CHK : S_REM_CHK;
            end
          end
          default: begin
            fin = 1'b1; fin_st = ST_NOT_FOUND;
          end
        endcase
      end
      S_GROW_LINK: begin
        meta_we = 1'b1; meta_wa = tail_r; meta_wd = '{valid: 1'b0, nxt: KW'(gk_r)};
        state_nxt = S_GROW_FILL;
      end
      S_GROW_FILL: begin
        meta_we = 1'b1;
        meta_wa = KW'(gk_r);
        meta_wd = '{valid: 1'b0, nxt: (gk_inc == gend_r) ? '0 : KW'(gk_inc)};
        if (empty_r) head_nxt = KW'(gk_r);
        empty_nxt = 1'b0;
        tail_nxt  = KW'(gk_r);
        gk_nxt    = gk_inc;
        if (gk_inc == gend_r) begin
          pop_nxt = gend_r;
          case (ret_r)
            RET_INS:   state_nxt = S_INS_RD;
            RET_INSAT: state_nxt = S_DISPATCH;
            default:   fin = 1'b1;
          endcase
        end
      end
      S_INS_RD: begin
        meta_ra = head_r;
        state_nxt = S_INS_UNL;
      end
      S_INS_UNL: begin
        if (tail_r == head_r) empty_nxt = 1'b1;
        else head_nxt = meta_rd_r.nxt;
        meta_we = 1'b1; meta_wa = head_r; meta_wd = '{valid: 1'b1, nxt: '0};
        val_we  = 1'b1;
        fin = 1'b1; fin_key = KEY_BITS'(head_r);
      end
      S_INSAT_CHK: begin
        knext_nxt = meta_rd_r.nxt;
        if (meta_rd_r.valid) begin
          fin = 1'b1; fin_st = ST_ALREADY;
        end else if (empty_r || head_r == tail_r && head_r != key_i) begin
          state_nxt = S_CLAIM;
        end else if (head_r == key_i) begin
          if (tail_r == key_i) empty_nxt = 1'b1;
          else head_nxt = meta_rd_r.nxt;
          state_nxt = S_CLAIM;
        end else begin
          prev_nxt  = head_r;
          meta_ra   = head_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (meta_rd_r.nxt == key_i) begin
          meta_we = 1'b1; meta_wa = prev_r; meta_wd = '{valid: 1'b0, nxt: knext_r};
          if (tail_r == key_i) tail_nxt = prev_r;
          state_nxt = S_CLAIM;
        end else begin
          prev_nxt = meta_rd_r.nxt;
          meta_ra  = meta_rd_r.nxt;
          if (meta_rd_r.nxt == tail_r) state_nxt = S_CLAIM;
        end
      end
      S_CLAIM: begin
        meta_we = 1'b1; meta_wd = '{valid: 1'b1, nxt: '0};
        val_we  = 1'b1;
        fin = 1'b1;
      end
      S_GET_CHK: begin
        fin = 1'b1;
        if (meta_rd_r.valid) fin_val = VAL_BITS'(val_rd_r);
        else fin_st = ST_NOT_FOUND;
      end
      S_REM_CHK: begin
        fin = 1'b1;
        if (!meta_rd_r.valid) begin
          fin_st = ST_NOT_FOUND;
        end else begin
          meta_we = 1'b1;
          meta_wd = '{valid: 1'b0, nxt: empty_r ? '0 : head_r};
          if (empty_r) tail_nxt = key_i;
          empty_nxt = 1'b0;
          head_nxt  = key_i;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      out_valid_nxt     = 1'b1;
      res_nxt.status    = fin_st;
      res_nxt.out_key   = fin_key;
      res_nxt.out_value = fin_val;
      state_nxt         = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_DONE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      pop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r  <= type_nxt;
    key_r   <= key_nxt;
    value_r <= value_nxt;
    prev_r  <= prev_nxt;
    knext_r <= knext_nxt;
    gk_r    <= gk_nxt;
    gend_r  <= gend_nxt;
    res_r   <= res_nxt;
  end

endmodule

### rtl/handle_table_key_allocator.sv
// After S_DISPATCH, get and remove pass a check state; insert S_INS_RD, S_INS_UNL; insert-at
// S_INSAT_CHK, S_CLAIM. Growth links a nonempty tail, fills keys, then rechecks insert-at.
// Insert-at of a key inside the free list walks the list at one entry per cycle.
// Throughput: one request at a time; the next request is taken once busy drops.
// Reset: synchronous active-low rst_n empties the table and restores register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
module handle_table_key_allocator #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 63
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hkal_pkg::req_t in_req,
  output logic           out_valid,
  output hkal_pkg::res_t out_res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import hkal_pkg::*;

  cfg_t cfg;

  hkal_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  hkal_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_req, .cfg, .out_valid, .out_res
  );

endmodule

### rtl/hkal_checker.sv
module hkal_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input hkal_pkg::res_t out_res
);
  import hkal_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after a request");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid) else $error("result right after a request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.status <= ST_NOT_POP) else $error("status code out of range");

endmodule

bind handle_table_key_allocator hkal_checker u_hkal_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_res
);

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hkal_pkg::*;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  req_t        in_req = '0;
  logic        busy;
  logic        out_valid;
  res_t        out_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  handle_table_key_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Table copy kept in step with the accepted requests.
  logic [VAL_BITS-1:0] slot_value [DEPTH];
  bit                  slot_used  [DEPTH];
  logic [KEY_BITS-1:0] free_link  [DEPTH];
  int free_first;
  int free_last;
  bit free_none = 1'b1;
  int populated = 0;
  int set_initial = INITIAL_RST;
  int set_grow = GROW_RST;
  int set_maximum = MAXIMUM_RST;

  req_t pending_reqs [$];
  res_t expected_res [$];
  int issued = 0;
  int accepted = 0;
  int results_seen = 0;
  int fails = 0;
  int quiet_cycles = 0;
  int gap = 0;
  bit steady = 1'b0;

  function automatic int key_limit();
    return (set_maximum > DEPTH) ? DEPTH : set_maximum;
  endfunction

  function automatic void append_free(int k);
    if (free_none) begin
      free_first = k;
      free_none = 1'b0;
    end else begin
      free_link[free_last] = KEY_BITS'(k);
    end
    free_last = k;
    free_link[k] = '0;
  endfunction

  function automatic bit extend_table(int step);
    int lim;
    lim = key_limit();
    if (populated >= lim) return 1'b0;
    if (step == 0) step = 1;
    if (step > lim - populated) step = lim - populated;
    for (int i = 0; i < step; i++) begin
      slot_used[populated + i] = 1'b0;
      append_free(populated + i);
    end
    populated += step;
    return 1'b1;
  endfunction

  function automatic void unlink_free(int k);
    int prev;
    if (free_none) return;
    if (free_first == k) begin
      if (free_last == k) free_none = 1'b1;
      else free_first = free_link[k];
      return;
    end
    prev = free_first;
    for (int n = 0; n < DEPTH && prev != free_last; n++) begin
      if (free_link[prev] == k) begin
        free_link[prev] = free_link[k];
        if (free_last == k) free_last = prev;
        return;
      end
      prev = free_link[prev];
    end
  endfunction

  function automatic res_t table_response(req_t r);
    res_t res;
    int k;
    bit ok;
    int init;
    k = r.req_key;
    res.status = ST_OK;
    res.out_key = r.req_key;
    res.out_value = '0;
    case (r.req_type)
      OP_INSERT: begin
        ok = 1'b1;
        if (free_none) ok = extend_table(set_grow);
        if (!ok) begin
          res.status = ST_NO_SPACE;
        end else begin
          k = free_first;
          unlink_free(k);
          slot_value[k] = r.req_value;
          slot_used[k] = 1'b1;
          res.out_key = KEY_BITS'(k);
        end
      end
      OP_INSERT_AT: begin
        if (k >= key_limit()) begin
          res.status = ST_BEYOND;
        end else begin
          ok = 1'b1;
          while (ok && k >= populated) ok = extend_table(set_grow);
          if (!ok) res.status = ST_NO_SPACE;
          else if (slot_used[k]) res.status = ST_ALREADY;
          else begin
            unlink_free(k);
            slot_value[k] = r.req_value;
            slot_used[k] = 1'b1;
          end
        end
      end
      OP_GET: begin
        if (k >= populated) res.status = ST_NOT_POP;
        else if (!slot_used[k]) res.status = ST_NOT_FOUND;
        else res.out_value = slot_value[k];
      end
      OP_REMOVE: begin
        if (k >= populated) res.status = ST_NOT_POP;
        else if (!slot_used[k]) res.status = ST_NOT_FOUND;
        else begin
          slot_used[k] = 1'b0;
          if (free_none) begin
            free_last = k;
            free_link[k] = '0;
            free_none = 1'b0;
          end else begin
            free_link[k] = KEY_BITS'(free_first);
          end
          free_first = k;
        end
      end
      OP_RESET: begin
        for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
        free_first = 0;
        free_last = 0;
        free_none = 1'b1;
        populated = 0;
        init = (set_initial > key_limit()) ? key_limit() : set_initial;
        if (init > 0) void'(extend_table(init));
      end
      default: res.status = ST_NOT_FOUND;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted != issued) begin
      start <= 1'b1;
    end else if (gap > 0) begin
      gap--;
      start <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      in_req <= pending_reqs.pop_front();
      start <= 1'b1;
      issued++;
      gap = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $error("result with no request outstanding: status %0d key %0d",
                 out_res.status, out_res.out_key);
          fails++;
        end else begin
          want = expected_res.pop_front();
          if (out_res.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_res.status);
            fails++;
          end
          if (out_res.out_key !== want.out_key) begin
            $error("out_key expected %0d got %0d", want.out_key, out_res.out_key);
            fails++;
          end
          if (out_res.out_value !== want.out_value) begin
            $error("out_value expected %h got %h", want.out_value, out_res.out_value);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        expected_res.push_back(table_response(in_req));
        accepted++;
      end
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_req(logic [2:0] op, int key, logic [VAL_BITS-1:0] value);
    req_t r;
    r.req_type = op;
    r.req_key = KEY_BITS'(key);
    r.req_value = value;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || accepted != issued || expected_res.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_INITIAL: set_initial = value & 11'h7ff;
      REG_GROW:    set_grow = value & 11'h7ff;
      default:     set_maximum = value & 11'h7ff;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(int init, int grow, int maximum, int count, int span, bit fresh);
    int r;
    logic [2:0] op;
    int key;
    write_reg(REG_INITIAL, init);
    write_reg(REG_GROW, grow);
    write_reg(REG_MAXIMUM, maximum);
    steady = ($urandom_range(0, 3) == 0);
    if (fresh) add_req(OP_RESET, $urandom_range(0, 1023), '0);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_INSERT;
      else if (r < 50) op = OP_INSERT_AT;
      else if (r < 75) op = OP_GET;
      else if (r < 95) op = OP_REMOVE;
      else if (r < 97) op = OP_RESET;
      else op = 3'($urandom_range(5, 7));
      key = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, span);
      add_req(op, key, VAL_BITS'({$urandom, $urandom}));
    end
    wait_idle();
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    add_req(OP_RESET, 1023, '1);
    add_req(OP_GET, 0, '0);
    add_req(OP_REMOVE, 0, '0);
    add_req(OP_INSERT, 1023, '1);
    add_req(OP_INSERT, 0, '0);
    add_req(OP_GET, 0, '0);
    add_req(OP_GET, 1, '0);
    add_req(OP_INSERT_AT, 1023, '1);
    add_req(OP_INSERT_AT, 1023, '0);
    add_req(OP_GET, 1023, '0);
    add_req(OP_REMOVE, 1023, '0);
    add_req(OP_REMOVE, 1023, '0);
    add_req(OP_GET, 1023, '0);
    add_req(OP_INSERT_AT, 500, 63'h2aaa_aaaa_aaaa_aaaa);
    add_req(OP_GET, 500, '0);
    add_req(OP_INSERT, 7, 63'h5555_5555_5555_5555);
    add_req(3'd5, 1023, '1);
    add_req(3'd6, 0, '1);
    add_req(3'd7, 512, '0);
    wait_idle();

    run_phase(0, 64, 1024, 300, 1023, 1'b1);
    run_phase(1024, 1, 1024, 250, 1023, 1'b1);
    run_phase(5, 1024, 16, 300, 20, 1'b1);
    run_phase(0, 0, 1, 150, 3, 1'b1);
    run_phase(3, 2, 8, 250, 12, 1'b1);
    run_phase(200, 7, 300, 200, 300, 1'b1);
    run_phase(200, 7, 40, 200, 300, 1'b0);
    run_phase(0, 1, 1024, 300, 60, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d results over eight register settings,", accepted,
             results_seen);
    $display("including growth by zero and full steps and a limit below the population.");
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### handle_table_key_allocator.f
rtl/hkal_pkg.sv
rtl/hkal_cfg.sv
rtl/hkal_ctrl.sv
rtl/handle_table_key_allocator.sv
rtl/hkal_checker.sv
dv/tb_top.sv
